/* design/ctc_pkg.sv */
// Shared types and constants for the calibrated temperature converter.
// Used by the channel interfaces, the multiply/divide unit and the top level.
`default_nettype none
package ctc_pkg;

    localparam int RAW_W  = 8;
    localparam int TEMP_W = 18;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 64;
    localparam int COEF_W = 48;
    localparam int NB_W   = 7;

    localparam logic [CIDX_W-1:0] CFG_MODEL  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_CALIB  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ENABLE = 2'd2;

    localparam logic [1:0] MODEL_LOW = 2'd0;
    localparam logic [1:0] MODEL_E   = 2'd2;
    localparam logic [1:0] MODEL_DEF = 2'd3;

    // Offsets and reference points in 1/512 degree units; T1SQ is in 1/512^2 units, TDEG and TSQ in whole degrees.
    localparam logic [15:0] OFF_LOW  = 16'd20992;
    localparam logic [15:0] OFF_STD  = 16'd512;
    localparam logic [16:0] T1_LOW   = 17'd30720;
    localparam logic [16:0] T1_STD   = 17'd46080;
    localparam logic [31:0] T1SQ_LOW = 32'd943718400;
    localparam logic [31:0] T1SQ_STD = 32'd2123366400;
    localparam logic [6:0]  TDEG_LOW = 7'd60;
    localparam logic [6:0]  TDEG_STD = 7'd90;
    localparam logic [12:0] TSQ_LOW  = 13'd3600;
    localparam logic [12:0] TSQ_STD  = 13'd8100;

    localparam logic signed [TEMP_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [TEMP_W-1:0] OUT_MIN = -18'sd131072;

    typedef enum logic {OP_MUL, OP_DIV} t_mdu_op;

    typedef struct packed {
        logic            start;
        t_mdu_op         op;
        logic            sub;
        logic [NB_W-1:0] nbits;
    } t_mdu_cmd;

    typedef enum logic [2:0] {M_IDLE, M_PREP, M_MUL, M_DIV, M_FIN} t_mdu_state;

    typedef enum logic [4:0] {
        S_IDLE, S_P, S_Q, S_D1, S_D2, S_NB, S_DB, S_NA, S_DA, S_C1, S_C2,
        S_RR, S_CA, S_CB, S_CC, S_FIN
    } t_state;

    function automatic logic signed [COEF_W-1:0] sat48(input logic [127:0] v);
        logic signed [COEF_W-1:0] res;
        if (v[127:COEF_W-1] == {(129-COEF_W){v[127]}}) begin
            res = v[COEF_W-1:0];
        end else if (v[127]) begin
            res = {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COEF_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* design/ctc_ifs.sv */
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on ctc_pkg for field widths.
`default_nettype none
interface ctc_in_if;
    logic                      valid;
    logic                      ready;
    logic [ctc_pkg::RAW_W-1:0] raw_high;
    logic [ctc_pkg::RAW_W-1:0] raw_low;
    modport source (output valid, raw_high, raw_low, input ready);
    modport sink (input valid, raw_high, raw_low, output ready);
endinterface

interface ctc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ctc_pkg::TEMP_W-1:0] temperature;
    logic                              clipped;
    logic                              calib_fault;
    modport source (output valid, temperature, clipped, calib_fault, input ready);
    modport sink (input valid, temperature, clipped, calib_fault, output ready);
endinterface

interface ctc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ctc_pkg::CIDX_W-1:0] index;
    logic [ctc_pkg::CDAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/ctc_mdu.sv */
// Shared bit-serial multiply-accumulate and restoring divide unit.
// One 128-bit adder serves every step. Depends on ctc_pkg.
`default_nettype none
module ctc_mdu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ctc_pkg::t_mdu_cmd i_cmd,
    input  wire logic signed [63:0] i_x,
    input  wire logic signed [63:0] i_y,
    input  wire logic [127:0]      i_acc,
    output logic                   o_done,
    output logic [127:0]           o_res
);
    ctc_pkg::t_mdu_state r_st, n_st;
    logic [7:0]   r_cnt, n_cnt;
    logic         r_neg, n_neg;
    logic [127:0] r_w, n_w;
    logic [127:0] r_mx, n_mx;
    logic [63:0]  r_my, n_my;
    logic [64:0]  r_rem, n_rem;
    logic [127:0] r_acc, n_acc;
    logic [127:0] r_res, n_res;
    logic         r_done, n_done;

    logic [127:0] opa, opb, sum;
    logic         cin;
    logic [63:0]  mag_x, mag_y;
    logic [64:0]  rem_sh;

    assign mag_x  = i_x[63] ? 64'd0 - i_x : i_x;
    assign mag_y  = i_y[63] ? 64'd0 - i_y : i_y;
    assign rem_sh = {r_rem[63:0], r_w[127]};
    assign sum    = opa + opb + {127'd0, cin};

    always_comb begin
        opa = '0;
        opb = '0;
        cin = 1'b0;
        unique case (r_st)
            ctc_pkg::M_PREP: begin
                opb = r_acc[127] ? ~r_acc : r_acc;
                cin = r_acc[127];
            end
            ctc_pkg::M_MUL: begin
                opa = r_w;
                opb = r_mx;
            end
            ctc_pkg::M_DIV: begin
                // Trial subtraction of the divisor from the shifted remainder.
                opa = {63'd0, rem_sh};
                opb = ~{64'd0, r_my};
                cin = 1'b1;
            end
            ctc_pkg::M_FIN: begin
                opa = r_acc;
                opb = r_neg ? ~r_w : r_w;
                cin = r_neg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_st   = r_st;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_w    = r_w;
        n_mx   = r_mx;
        n_my   = r_my;
        n_rem  = r_rem;
        n_acc  = r_acc;
        n_res  = r_res;
        n_done = 1'b0;
        unique case (r_st)
            ctc_pkg::M_IDLE: begin
                if (i_cmd.start) begin
                    n_acc = i_acc;
                    n_my  = mag_y;
                    if (i_cmd.op == ctc_pkg::OP_MUL) begin
                        n_mx  = {64'd0, mag_x};
                        n_w   = '0;
                        n_neg = i_x[63] ^ i_y[63] ^ i_cmd.sub;
                        n_cnt = {1'b0, i_cmd.nbits};
                        n_st  = ctc_pkg::M_MUL;
                    end else begin
                        n_neg = i_acc[127] ^ i_y[63];
                        n_cnt = 8'd128;
                        n_st  = ctc_pkg::M_PREP;
                    end
                end
            end
            ctc_pkg::M_PREP: begin
                n_w   = sum;
                n_acc = '0;
                n_rem = '0;
                n_st  = ctc_pkg::M_DIV;
            end
            ctc_pkg::M_MUL: begin
                if (r_my[0]) begin
                    n_w = sum;
                end
                n_mx  = {r_mx[126:0], 1'b0};
                n_my  = {1'b0, r_my[63:1]};
                n_cnt = r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    n_st = ctc_pkg::M_FIN;
                end
            end
            ctc_pkg::M_DIV: begin
                n_rem = sum[127] ? rem_sh : sum[64:0];
                n_w   = {r_w[126:0], ~sum[127]};
                n_cnt = r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    n_st = ctc_pkg::M_FIN;
                end
            end
            ctc_pkg::M_FIN: begin
                n_res  = sum;
                n_done = 1'b1;
                n_st   = ctc_pkg::M_IDLE;
            end
            default: begin
                n_st = ctc_pkg::M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ctc_pkg::M_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_w   <= n_w;
        r_mx  <= n_mx;
        r_my  <= n_my;
        r_rem <= n_rem;
        r_acc <= n_acc;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
`default_nettype wire

/* design/calibrated_temperature_converter_core.sv */
// Top level of the calibrated temperature converter: register file, sequencer
// and output register. Depends on ctc_pkg, ctc_ifs and ctc_mdu.
//
// Each sample is turned into a temperature in units of 2^-TEMP_FRAC_BITS
// degree, optionally minus the quadratic correction a*r*r + b*r + c. All
// products and quotients use one shared unit that handles one multiplier or
// quotient bit per cycle, so the block takes one sample at a time. A sample
// that gets the correction runs four serial multiplies. The first sample
// after reset or after a write to the model, calibration or enable register
// also rebuilds the coefficients first, with two 128-step divisions
// unless the divisor is zero. The result sits in an output register, so
// the next sample can be taken while it waits to be transferred.
`default_nettype none
module calibrated_temperature_converter_core #(
    parameter int TEMP_FRAC_BITS = 9
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ctc_in_if.sink     i_in,
    ctc_cfg_if.sink    i_cfg,
    ctc_out_if.source  o_out
);
    localparam int SH = 58 - TEMP_FRAC_BITS;

    ctc_pkg::t_state r_state, n_state;
    logic [1:0]  r_model, n_model;
    logic [63:0] r_calib, n_calib;
    logic        r_en, n_en;
    logic signed [47:0] r_ca, n_ca, r_cb, n_cb, r_cc, n_cc;
    logic        r_cready, n_cready, r_cbad, n_cbad;
    logic signed [17:0] r_r, n_r;
    logic        r_want, n_want;
    logic signed [33:0] r_p, n_p, r_q, n_q;
    logic signed [55:0] r_d, n_d;
    logic [127:0] r_acc, n_acc;
    logic        r_issued, n_issued;
    logic        r_ov, n_ov;
    logic signed [17:0] r_temp, n_temp;
    logic        r_clip, n_clip, r_fault, n_fault;

    ctc_pkg::t_mdu_cmd m_cmd;
    logic signed [63:0] m_x, m_y;
    logic [127:0] m_acc, m_res;
    logic        m_done;

    logic        is_low;
    logic [15:0] off;
    logic signed [17:0] t1, tr2, tc2, tr3, tc3, e1;
    logic signed [18:0] de;
    logic [31:0] t1sq;
    logic [6:0]  tdeg;
    logic [12:0] tsq;
    logic signed [127:0] fl, v;
    logic        adj, clip;
    logic signed [17:0] temp;

    ctc_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (m_cmd),
        .i_x     (m_x),
        .i_y     (m_y),
        .i_acc   (m_acc),
        .o_done  (m_done),
        .o_res   (m_res)
    );

    assign is_low = (r_model == ctc_pkg::MODEL_LOW);
    assign off  = is_low ? ctc_pkg::OFF_LOW : ctc_pkg::OFF_STD;
    assign t1   = $signed({1'b0, is_low ? ctc_pkg::T1_LOW : ctc_pkg::T1_STD});
    assign t1sq = is_low ? ctc_pkg::T1SQ_LOW : ctc_pkg::T1SQ_STD;
    assign tdeg = is_low ? ctc_pkg::TDEG_LOW : ctc_pkg::TDEG_STD;
    assign tsq  = is_low ? ctc_pkg::TSQ_LOW : ctc_pkg::TSQ_STD;
    assign tr2  = $signed({2'b0, r_calib[7:0], r_calib[15:8]}) - $signed({2'b0, off});
    assign tc2  = $signed({2'b0, r_calib[23:16], r_calib[31:24]}) - $signed({2'b0, off});
    assign tr3  = $signed({2'b0, r_calib[39:32], r_calib[47:40]}) - $signed({2'b0, off});
    assign tc3  = $signed({2'b0, r_calib[55:48], r_calib[63:56]}) - $signed({2'b0, off});
    assign e1   = tc2 - tr2;
    assign de   = 19'(tc3 - tr3) - 19'(e1);

    // Truncation toward zero: floor shift, then bump negative values that
    // lost nonzero fraction bits.
    assign fl   = $signed(r_acc) >>> SH;
    assign adj  = r_acc[127] && (r_acc[SH-1:0] != '0);
    assign v    = fl + $signed({127'd0, adj});
    assign clip = (v[127:17] != {111{v[127]}});
    assign temp = clip ? (v[127] ? ctc_pkg::OUT_MIN : ctc_pkg::OUT_MAX) : v[17:0];

    assign i_in.ready  = (r_state == ctc_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid       = r_ov;
    assign o_out.temperature = r_temp;
    assign o_out.clipped     = r_clip;
    assign o_out.calib_fault = r_fault;

    always_comb begin
        n_state  = r_state;
        n_model  = r_model;
        n_calib  = r_calib;
        n_en     = r_en;
        n_ca     = r_ca;
        n_cb     = r_cb;
        n_cc     = r_cc;
        n_cready = r_cready;
        n_cbad   = r_cbad;
        n_r      = r_r;
        n_want   = r_want;
        n_p      = r_p;
        n_q      = r_q;
        n_d      = r_d;
        n_acc    = r_acc;
        n_issued = r_issued;
        n_ov     = r_ov && !o_out.ready;
        n_temp   = r_temp;
        n_clip   = r_clip;
        n_fault  = r_fault;
        m_cmd.start = 1'b0;
        m_cmd.op    = ctc_pkg::OP_MUL;
        m_cmd.sub   = 1'b0;
        m_cmd.nbits = 7'd17;
        m_x   = '0;
        m_y   = '0;
        m_acc = '0;

        unique case (r_state)
            ctc_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_r = $signed({2'b0, i_in.raw_high, i_in.raw_low}) - $signed({2'b0, off});
                    n_want  = r_en && (r_model != ctc_pkg::MODEL_E);
                    n_state = r_cready ? ctc_pkg::S_RR : ctc_pkg::S_P;
                end
            end
            ctc_pkg::S_P, ctc_pkg::S_Q: begin
                m_x   = (r_state == ctc_pkg::S_P) ? 64'(tr2) : 64'(tr3);
                m_y   = m_x;
                m_acc = 128'd0 - {96'd0, t1sq};
            end
            ctc_pkg::S_D1: begin
                m_x = 64'(r_p);
                m_y = 64'(tr3 - t1);
            end
            ctc_pkg::S_D2: begin
                m_x   = 64'(r_q);
                m_y   = 64'(t1 - tr2);
                m_acc = 128'(r_d);
            end
            ctc_pkg::S_NB: begin
                m_x = 64'(r_p);
                m_y = 64'(de);
                m_cmd.nbits = 7'd18;
            end
            ctc_pkg::S_NA: begin
                m_x = 64'(t1 - tr2);
                m_y = 64'(de);
                m_cmd.nbits = 7'd18;
            end
            ctc_pkg::S_DB: begin
                m_cmd.op = ctc_pkg::OP_DIV;
                m_y   = 64'(r_d);
                m_acc = {r_acc[87:0], 40'd0};
            end
            ctc_pkg::S_DA: begin
                m_cmd.op = ctc_pkg::OP_DIV;
                m_y   = 64'(r_d);
                m_acc = {r_acc[78:0], 49'd0};
            end
            ctc_pkg::S_C1: begin
                m_cmd.sub   = 1'b1;
                m_cmd.nbits = 7'd13;
                m_x   = 64'(r_ca);
                m_y   = {51'd0, tsq};
                m_acc = 128'(e1) << 31;
            end
            ctc_pkg::S_C2: begin
                m_cmd.sub   = 1'b1;
                m_cmd.nbits = 7'd7;
                m_x   = 64'(r_cb);
                m_y   = {57'd0, tdeg};
                m_acc = r_acc;
            end
            ctc_pkg::S_RR: begin
                m_x = 64'(r_r);
                m_y = 64'(r_r);
            end
            ctc_pkg::S_CA: begin
                m_cmd.sub   = 1'b1;
                m_cmd.nbits = 7'd33;
                m_x   = 64'(r_ca);
                m_y   = r_acc[63:0];
                m_acc = 128'(r_r) << 49;
            end
            ctc_pkg::S_CB: begin
                m_cmd.sub   = 1'b1;
                m_cmd.nbits = 7'd27;
                m_x   = 64'(r_cb);
                m_y   = 64'(r_r) << 9;
                m_acc = r_acc;
            end
            ctc_pkg::S_CC: begin
                m_cmd.sub   = 1'b1;
                m_cmd.nbits = 7'd19;
                m_x   = 64'(r_cc);
                m_y   = 64'h40000;
                m_acc = r_acc;
            end
            ctc_pkg::S_FIN: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_temp  = temp;
                    n_clip  = clip;
                    n_fault = r_want && r_cbad;
                    n_state = ctc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ctc_pkg::S_IDLE;
            end
        endcase

        // States but idle and finish run a unit op, bar an uncorrected RR.
        if (r_state != ctc_pkg::S_IDLE && r_state != ctc_pkg::S_FIN) begin
            if (r_state == ctc_pkg::S_RR && !(r_want && !r_cbad)) begin
                n_acc   = 128'(r_r) << 49;
                n_state = ctc_pkg::S_FIN;
            end else begin
                m_cmd.start = !r_issued;
                n_issued    = 1'b1;
                if (m_done) begin
                    n_issued = 1'b0;
                    unique case (r_state)
                        ctc_pkg::S_P:  begin n_p = m_res[33:0]; n_state = ctc_pkg::S_Q; end
                        ctc_pkg::S_Q:  begin n_q = m_res[33:0]; n_state = ctc_pkg::S_D1; end
                        ctc_pkg::S_D1: begin n_d = m_res[55:0]; n_state = ctc_pkg::S_D2; end
                        ctc_pkg::S_D2: begin
                            n_d = m_res[55:0];
                            if (m_res == '0) begin
                                n_cbad   = 1'b1;
                                n_cready = 1'b1;
                                n_ca     = '0;
                                n_cb     = '0;
                                n_cc     = '0;
                                n_state  = ctc_pkg::S_RR;
                            end else begin
                                n_state = ctc_pkg::S_NB;
                            end
                        end
                        ctc_pkg::S_NB: begin n_acc = m_res; n_state = ctc_pkg::S_DB; end
                        ctc_pkg::S_DB: begin
                            n_cb = ctc_pkg::sat48(m_res); n_state = ctc_pkg::S_NA;
                        end
                        ctc_pkg::S_NA: begin n_acc = m_res; n_state = ctc_pkg::S_DA; end
                        ctc_pkg::S_DA: begin
                            n_ca = ctc_pkg::sat48(m_res); n_state = ctc_pkg::S_C1;
                        end
                        ctc_pkg::S_C1: begin n_acc = m_res; n_state = ctc_pkg::S_C2; end
                        ctc_pkg::S_C2: begin
                            n_cc     = ctc_pkg::sat48(m_res);
                            n_cready = 1'b1;
                            n_cbad   = 1'b0;
                            n_state  = ctc_pkg::S_RR;
                        end
                        ctc_pkg::S_RR: begin n_acc = m_res; n_state = ctc_pkg::S_CA; end
                        ctc_pkg::S_CA: begin n_acc = m_res; n_state = ctc_pkg::S_CB; end
                        ctc_pkg::S_CB: begin n_acc = m_res; n_state = ctc_pkg::S_CC; end
                        default: begin n_acc = m_res; n_state = ctc_pkg::S_FIN; end
                    endcase
                end
            end
        end

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ctc_pkg::CFG_MODEL: begin
                    n_model = i_cfg.data[1:0]; n_cready = 1'b0;
                end
                ctc_pkg::CFG_CALIB: begin
                    n_calib = i_cfg.data; n_cready = 1'b0;
                end
                ctc_pkg::CFG_ENABLE: begin
                    n_en = i_cfg.data[0]; n_cready = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ctc_pkg::S_IDLE;
            r_model  <= ctc_pkg::MODEL_DEF;
            r_calib  <= '0;
            r_en     <= 1'b0;
            r_ca     <= '0;
            r_cb     <= '0;
            r_cc     <= '0;
            r_cready <= 1'b0;
            r_cbad   <= 1'b0;
            r_issued <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_model  <= n_model;
            r_calib  <= n_calib;
            r_en     <= n_en;
            r_ca     <= n_ca;
            r_cb     <= n_cb;
            r_cc     <= n_cc;
            r_cready <= n_cready;
            r_cbad   <= n_cbad;
            r_issued <= n_issued;
            r_ov     <= n_ov;
        end
        r_r     <= n_r;
        r_want  <= n_want;
        r_p     <= n_p;
        r_q     <= n_q;
        r_d     <= n_d;
        r_acc   <= n_acc;
        r_temp  <= n_temp;
        r_clip  <= n_clip;
        r_fault <= n_fault;
    end
endmodule
`default_nettype wire

/* dv/calibrated_temperature_converter_core_tb.sv */
// Self-checking testbench for calibrated_temperature_converter_core.
// Depends on ctc_pkg and the channel interfaces in ctc_ifs; untyped table rows, then
// random phases are checked against a predictor of the conversion and correction math.
module calibrated_temperature_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]                 MODEL_T  = 2'd1;
    localparam logic [ctc_pkg::CIDX_W-1:0] CFG_NONE = 2'd3;
    localparam int                         FRAC     = 9;
    localparam int                         SHIFT    = 58 - FRAC;

    typedef struct {
        logic signed [ctc_pkg::TEMP_W-1:0] temperature;
        logic                              clipped;
        logic                              calib_fault;
    } t_temp_res;

    typedef struct {
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [1:0]  model;
        logic        en;
        logic [63:0] calib;
        logic        typed;
        t_temp_res   res;
    } t_sample_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors = 0;
    bit   quiet = 1'b0;
    bit   hold_req = 1'b0;
    t_temp_res temp_q[$];

    // Predictor state.
    logic [1:0]         p_model = ctc_pkg::MODEL_DEF;
    logic [63:0]        p_calib = '0;
    logic               p_en = 1'b0;
    logic signed [47:0] c_quad = '0, c_lin = '0, c_const = '0;
    logic               c_ready = 1'b0, c_bad = 1'b0;

    ctc_in_if  in_if();
    ctc_cfg_if cfg_if();
    ctc_out_if out_if();

    calibrated_temperature_converter_core #(.TEMP_FRAC_BITS(FRAC)) dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in(in_if), .i_cfg(cfg_if), .o_out(out_if)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [47:0] clamp48(input logic signed [127:0] v);
        logic signed [127:0] hi_lim, lo_lim;
        hi_lim = (128'sd1 <<< 47) - 1;
        lo_lim = -(128'sd1 <<< 47);
        if (v > hi_lim) return hi_lim[47:0];
        if (v < lo_lim) return lo_lim[47:0];
        return v[47:0];
    endfunction

    function automatic longint calib_word(input int k, input logic [63:0] cb, input longint off);
        return longint'(cb[16*k +: 8]) * 256 + longint'(cb[16*k + 8 +: 8]) - off * 512;
    endfunction

    task automatic derive_coefs();
        longint off, tdeg, t1, tr2, tc2, tr3, tc3, e1, de, p, q, d;
        logic signed [127:0] w;
        off  = (p_model == ctc_pkg::MODEL_LOW) ? 41 : 1;
        tdeg = (p_model == ctc_pkg::MODEL_LOW) ? 60 : 90;
        t1   = tdeg * 512;
        tr2  = calib_word(0, p_calib, off);
        tc2  = calib_word(1, p_calib, off);
        tr3  = calib_word(2, p_calib, off);
        tc3  = calib_word(3, p_calib, off);
        e1   = tc2 - tr2;
        de   = (tc3 - tr3) - e1;
        p    = tr2 * tr2 - t1 * t1;
        q    = tr3 * tr3 - t1 * t1;
        d    = p * (tr3 - t1) + q * (t1 - tr2);
        c_ready = 1'b1;
        if (d == 0) begin
            c_bad = 1'b1;
            c_quad = '0; c_lin = '0; c_const = '0;
        end else begin
            c_bad = 1'b0;
            // Signed division truncates toward zero, then the quotient saturates.
            w = (128'(signed'(p * de)) <<< 40) / 128'(signed'(d));
            c_lin = clamp48(w);
            w = (128'(signed'((t1 - tr2) * de)) <<< 49) / 128'(signed'(d));
            c_quad = clamp48(w);
            w = (128'(signed'(e1)) <<< 31) - 128'(c_quad) * tdeg * tdeg
                - 128'(c_lin) * tdeg;
            c_const = clamp48(w);
        end
    endtask

    task automatic convert_sample(input logic [7:0] hi, input logic [7:0] lo,
                                  output t_temp_res res);
        longint off, r;
        logic want, neg;
        logic signed [127:0] total, mag;
        off  = (p_model == ctc_pkg::MODEL_LOW) ? 41 : 1;
        r    = longint'(hi) * 256 + longint'(lo) - off * 512;
        want = p_en && (p_model != ctc_pkg::MODEL_E);
        if (!c_ready) derive_coefs();
        total = 128'(signed'(r)) <<< 49;
        if (want && !c_bad) begin
            total = total - 128'(c_quad) * 128'(signed'(r * r))
                    - 128'(c_lin) * 128'(signed'(r * 512))
                    - (128'(c_const) <<< 18);
        end
        neg = total < 0;
        mag = neg ? -total : total;
        mag = mag >>> SHIFT;
        res.clipped = 1'b0;
        if (neg && mag > 131072) begin
            res.temperature = ctc_pkg::OUT_MIN; res.clipped = 1'b1;
        end else if (!neg && mag > 131071) begin
            res.temperature = ctc_pkg::OUT_MAX; res.clipped = 1'b1;
        end else begin
            res.temperature = neg ? -mag[ctc_pkg::TEMP_W-1:0] : mag[ctc_pkg::TEMP_W-1:0];
        end
        res.calib_fault = want && c_bad;
    endtask

    // Leaves valid high; the caller lowers it once the run of writes is over.
    task automatic write_reg(input logic [ctc_pkg::CIDX_W-1:0] idx, input logic [63:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            ctc_pkg::CFG_MODEL:  p_model = val[1:0];
            ctc_pkg::CFG_CALIB:  p_calib = val;
            ctc_pkg::CFG_ENABLE: p_en = val[0];
            default: ;
        endcase
        if (idx != CFG_NONE) c_ready = 1'b0;
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (temp_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] m, input logic [63:0] cb, input logic e,
                              input bit stray);
        wait_drained();
        if (stray) write_reg(CFG_NONE, {$urandom, $urandom});
        write_reg(ctc_pkg::CFG_CALIB, cb);
        write_reg(ctc_pkg::CFG_MODEL, {62'd0, m});
        write_reg(ctc_pkg::CFG_ENABLE, {63'd0, e});
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [7:0] hi, input logic [7:0] lo,
                               input bit typed, input t_temp_res typed_res);
        t_temp_res res;
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.raw_high <= hi;
        in_if.raw_low  <= lo;
        do @(posedge clk); while (!in_if.ready);
        convert_sample(hi, lo, res);
        temp_q.push_back(typed ? typed_res : res);
    endtask

    function automatic logic [63:0] plausible_calib();
        logic [15:0] r2, c2, r3, c3;
        r2 = 16'($urandom_range(6000, 40000));
        c2 = r2 + 16'($urandom_range(0, 600)) - 16'd300;
        r3 = 16'($urandom_range(42000, 62000));
        c3 = r3 + 16'($urandom_range(0, 900)) - 16'd450;
        return {c3[7:0], c3[15:8], r3[7:0], r3[15:8], c2[7:0], c2[15:8], r2[7:0], r2[15:8]};
    endfunction

    // Result checker.
    always @(posedge clk) begin
        t_temp_res want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (temp_q.size() == 0) begin
                $error("result transfer with nothing expected: temperature %0d",
                       out_if.temperature);
                errors++;
            end else begin
                want = temp_q.pop_front();
                if (out_if.temperature !== want.temperature) begin
                    $error("temperature: expected %0d, got %0d", want.temperature,
                           out_if.temperature);
                    errors++;
                end
                if (out_if.clipped !== want.clipped) begin
                    $error("clipped: expected %0b, got %0b", want.clipped, out_if.clipped);
                    errors++;
                end
                if (out_if.calib_fault !== want.calib_fault) begin
                    $error("calib_fault: expected %0b, got %0b", want.calib_fault,
                           out_if.calib_fault);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none when quiet.
    initial begin
        int stall;
        stall = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall = 400;
            end else if (stall == 0 && !quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 15);
            end
            if (stall > 0) stall--;
            out_if.ready <= rst_n && (stall == 0);
        end
    end

    initial begin
        t_sample_row rows[$];
        logic [63:0] cb;
        logic [1:0]  m;
        t_temp_res   none;
        localparam logic [63:0] CAL_A = 64'h8090_0090_4030_0030;
        in_if.valid = 1'b0; in_if.raw_high = '0; in_if.raw_low = '0;
        cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
        none = '{0, 1'b0, 1'b0};
        rows = '{
            '{8'd0,   8'd0,   ctc_pkg::MODEL_DEF, 1'b0, 64'd0, 1'b1, '{-512,   1'b0, 1'b0}},
            '{8'd255, 8'd255, ctc_pkg::MODEL_DEF, 1'b0, 64'd0, 1'b1, '{65023,  1'b0, 1'b0}},
            '{8'd2,   8'd0,   ctc_pkg::MODEL_DEF, 1'b0, 64'd0, 1'b1, '{0,      1'b0, 1'b0}},
            '{8'd128, 8'd0,   ctc_pkg::MODEL_DEF, 1'b0, 64'd0, 1'b1, '{32256,  1'b0, 1'b0}},
            '{8'd0,   8'd0,   ctc_pkg::MODEL_LOW, 1'b0, 64'd0, 1'b1, '{-20992, 1'b0, 1'b0}},
            '{8'd255, 8'd255, ctc_pkg::MODEL_LOW, 1'b0, 64'd0, 1'b1, '{44543,  1'b0, 1'b0}},
            '{8'd82,  8'd0,   ctc_pkg::MODEL_LOW, 1'b0, 64'd0, 1'b1, '{0,      1'b0, 1'b0}},
            '{8'd2,   8'd0,   ctc_pkg::MODEL_DEF, 1'b1, 64'd0, 1'b1, '{0,      1'b0, 1'b1}},
            '{8'd255, 8'd255, ctc_pkg::MODEL_DEF, 1'b1, 64'd0, 1'b1, '{65023,  1'b0, 1'b1}},
            '{8'd2,   8'd0,   ctc_pkg::MODEL_E,   1'b1, 64'd0, 1'b1, '{0,      1'b0, 1'b0}},
            '{8'd82,  8'd0,   ctc_pkg::MODEL_LOW, 1'b1, 64'd0, 1'b1, '{0,      1'b0, 1'b1}},
            '{8'd0,   8'd0,   MODEL_T,            1'b1, CAL_A, 1'b0, none},
            '{8'd255, 8'd255, MODEL_T,            1'b1, CAL_A, 1'b0, none},
            '{8'd48,  8'd0,   MODEL_T,            1'b1, CAL_A, 1'b0, none},
            '{8'd144, 8'd128, MODEL_T,            1'b1, CAL_A, 1'b0, none},
            '{8'd0,   8'd0,   ctc_pkg::MODEL_LOW, 1'b1, CAL_A, 1'b0, none},
            '{8'd255, 8'd255, ctc_pkg::MODEL_LOW, 1'b1, CAL_A, 1'b0, none},
            '{8'd170, 8'd85,  ctc_pkg::MODEL_E,   1'b1, CAL_A, 1'b0, none},
            '{8'd85,  8'd170, ctc_pkg::MODEL_DEF, 1'b1, {64{1'b1}}, 1'b0, none},
            '{8'd200, 8'd1,   ctc_pkg::MODEL_DEF, 1'b1, 64'h00FF_00FF_FF00_FF00, 1'b0, none},
            '{8'd0,   8'd255, ctc_pkg::MODEL_DEF, 1'b1, 64'hFF00_FF00_00FF_00FF, 1'b0, none}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            if (rows[i].model != p_model || rows[i].en != p_en || rows[i].calib != p_calib)
                set_config(rows[i].model, rows[i].calib, rows[i].en, 1'b0);
            send_sample(rows[i].hi, rows[i].lo, rows[i].typed, rows[i].res);
        end

        for (int ph = 0; ph < 20; ph++) begin
            m = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       cb = '0;
                1:       cb = {64{1'b1}};
                2, 3:    cb = {$urandom, $urandom};
                default: cb = plausible_calib();
            endcase
            set_config(m, cb, ph % 5 != 1, $urandom_range(0, 3) == 0);
            quiet = (ph >= 18);
            for (int k = 0; k < 50; k++) begin
                if (ph == 3 && k == 5) hold_req = 1'b1;
                if (ph == 6 && k == 25) wait_drained();
                if ($urandom_range(0, 3) == 0)
                    send_sample(8'($urandom), 8'd0, 1'b0, none);
                else
                    send_sample(8'($urandom), 8'($urandom), 1'b0, none);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
